### rtl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/ihsp_pkg.sv
package ihsp_pkg;

	localparam int HEADER_BYTES   = 24;
	localparam int FILE_LEN_RESET = 24;

	// Byte queue between the front and back ends
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FMT_NONE = 2'd0,
		FMT_JPEG = 2'd1,
		FMT_GIF  = 2'd2,
		FMT_PNG  = 2'd3
	} img_fmt_t;

	// One file byte tagged with its offset; last marks the file's final byte
	typedef struct packed {
		logic        last;
		logic [31:0] idx;
		logic [7:0]  data;
	} qent_t;

endpackage

### rtl/ihsp_front.sv
module ihsp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          data_valid,
	output logic          data_stall,
	input  logic [7:0]    data_byte,
	input  logic [31:0]   file_length,
	input  logic          q_full,
	output logic          push,
	output ihsp_pkg::qent_t push_ent
);
	import ihsp_pkg::*;

	logic [31:0] idx_q;
	logic        is_last;

	assign data_stall = q_full;
	assign push       = data_valid && !q_full;

	// offset wraps at 32 bits, same as the byte counter it models
	assign is_last = (idx_q == (file_length - 32'd1));

	assign push_ent.last = is_last;
	assign push_ent.idx  = idx_q;
	assign push_ent.data = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			idx_q <= is_last ? 32'd0 : idx_q + 32'd1;
		end
	end

endmodule

### rtl/ihsp_queue.sv
module ihsp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ihsp_pkg::qent_t push_ent,
	input  logic          pop,
	output ihsp_pkg::qent_t head,
	output logic          q_full,
	output logic          q_valid
);
	import ihsp_pkg::*;

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/ihsp_back.sv
module ihsp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  ihsp_pkg::qent_t head,
	output logic          pop,
	input  logic [31:0]   file_length,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [1:0]    image_format,
	output logic [31:0]   image_width,
	output logic [31:0]   image_height
);
	import ihsp_pkg::*;

	localparam int HIDX_W = $clog2(HEADER_BYTES);

	localparam logic [7:0] B_FF  = 8'hFF;
	localparam logic [7:0] B_SOI = 8'hD8;
	localparam logic [7:0] B_APP = 8'hE0;
	localparam logic [7:0] B_J   = 8'h4A;
	localparam logic [7:0] B_F   = 8'h46;
	localparam logic [7:0] B_I   = 8'h49;
	localparam logic [7:0] B_G   = 8'h47;
	localparam logic [7:0] B_P   = 8'h50;
	localparam logic [7:0] B_N   = 8'h4E;
	localparam logic [7:0] B_H   = 8'h48;
	localparam logic [7:0] B_D   = 8'h44;
	localparam logic [7:0] B_R   = 8'h52;
	localparam logic [7:0] B_PNG = 8'h89;
	localparam logic [7:0] B_CR  = 8'h0D;
	localparam logic [7:0] B_LF  = 8'h0A;
	localparam logic [7:0] B_EOF = 8'h1A;

	localparam logic [31:0] OFS_SOI_END  = 32'd3;
	localparam logic [31:0] OFS_JFIF_END = 32'd9;
	localparam logic [31:0] SP_RESET     = 32'd2;

	function automatic logic is_sof(input logic [7:0] m);
		case (m)
			8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB: is_sof = 1'b1;
			default:                                       is_sof = 1'b0;
		endcase
	endfunction

	// header bytes and the last three bytes of the stream
	logic [7:0]  hdr_q [HEADER_BYTES];
	logic [7:0]  r1_q, r2_q, r3_q;

	// segment walk
	logic [31:0] sp_q;
	logic [32:0] sp2_q;   // sp_q + 2, registered from sp_q so it trails sp_q
	logic [32:0] sp14_q;  // sp_q + 14, registered from sp_q so it trails sp_q
	logic        walk_q, fin_q, mok_q;
	logic [31:0] held_q;

	logic        res_valid_q;
	logic [1:0]  res_fmt_q;
	logic [31:0] res_wid_q, res_hgt_q;

	logic [7:0]  b;
	logic [31:0] idx;
	logic        in_hdr;
	logic [HIDX_W-1:0] hidx;
	logic [7:0]  h [HEADER_BYTES];
	logic        soi_app, jfif_tag;
	logic [32:0] win_ofs;
	logic        at_window, in_dim;
	logic [15:0] seg;
	logic [33:0] lim, np;
	logic        over;
	logic        walk_n, fin_n, mok_n;
	logic [31:0] sp_n, held_n;
	img_fmt_t    fmt;
	logic [31:0] wid, hgt;

	assign b      = head.data;
	assign idx    = head.idx;
	assign pop    = q_valid && !(head.last && res_valid_q && result_stall);
	assign in_hdr = (idx < 32'(HEADER_BYTES));
	assign hidx   = idx[HIDX_W-1:0];

	always_comb begin
		for (int k = 0; k < HEADER_BYTES; k++) begin
			h[k] = (in_hdr && (hidx == HIDX_W'(k))) ? b : hdr_q[k];
		end
	end

	assign soi_app  = (h[0] == B_FF) && (h[1] == B_SOI) && (h[2] == B_FF) && (h[3] == B_APP);
	assign jfif_tag = (h[6] == B_J) && (h[7] == B_F) && (h[8] == B_I) && (h[9] == B_F);

	// offset of the byte within the current window
	assign win_ofs   = {1'b0, idx} - {1'b0, sp_q};
	assign at_window = (win_ofs == 33'd3);
	assign in_dim    = (win_ofs == 33'd5) || (win_ofs == 33'd6) || (win_ofs == 33'd7) ||
		(win_ofs == 33'd8);

	assign seg  = {r1_q, b};
	assign lim  = {1'b0, sp14_q} + 34'(seg);
	assign np   = {1'b0, sp2_q} + 34'(seg);
	assign over = (lim > {2'b00, file_length});

	always_comb begin
		walk_n = walk_q;
		fin_n  = fin_q;
		mok_n  = mok_q;
		sp_n   = sp_q;
		if (idx == OFS_SOI_END) begin
			walk_n = soi_app;
		end
		if ((idx == OFS_JFIF_END) && !jfif_tag) begin
			walk_n = 1'b0;
		end
		if (walk_n && at_window) begin
			if (r3_q != B_FF) begin
				fin_n  = 1'b1;
				mok_n  = 1'b0;
				walk_n = 1'b0;
			end else if (is_sof(r2_q) || over) begin
				fin_n  = 1'b1;
				mok_n  = 1'b1;
				walk_n = 1'b0;
			end else begin
				sp_n = np[31:0];
			end
		end
		// a new window never places this byte among its dimension bytes, so the old position decides
		held_n = in_dim ? {held_q[23:0], b} : held_q;
	end

	always_comb begin
		fmt = FMT_NONE;
		wid = '0;
		hgt = '0;
		if (file_length >= 32'(HEADER_BYTES)) begin
			if (soi_app && jfif_tag) begin
				if (fin_n && mok_n) begin
					fmt = FMT_JPEG;
					hgt = {16'h0, held_n[31:16]};
					wid = {16'h0, held_n[15:0]};
				end
			end else if ((h[0] == B_FF) && (h[1] == B_SOI) && (h[2] == B_FF)) begin
				fmt = FMT_JPEG;
				hgt = {16'h0, h[7], h[8]};
				wid = {16'h0, h[9], h[10]};
			end else if ((h[0] == B_G) && (h[1] == B_I) && (h[2] == B_F)) begin
				fmt = FMT_GIF;
				wid = {16'h0, h[7], h[6]};
				hgt = {16'h0, h[9], h[8]};
			end else if ((h[0] == B_PNG) && (h[1] == B_P) && (h[2] == B_N) && (h[3] == B_G) &&
					(h[4] == B_CR) && (h[5] == B_LF) && (h[6] == B_EOF) && (h[7] == B_LF) &&
					(h[12] == B_I) && (h[13] == B_H) && (h[14] == B_D) && (h[15] == B_R)) begin
				fmt = FMT_PNG;
				wid = {h[16], h[17], h[18], h[19]};
				hgt = {h[20], h[21], h[22], h[23]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (in_hdr) begin
				hdr_q[hidx] <= b;
			end
			r1_q <= b;
			r2_q <= r1_q;
			r3_q <= r2_q;
		end
		if (pop && head.last) begin
			res_fmt_q <= fmt;
			res_wid_q <= wid;
			res_hgt_q <= hgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= SP_RESET;
			sp2_q       <= 33'd4;
			sp14_q      <= 33'd16;
			walk_q      <= 1'b0;
			fin_q       <= 1'b0;
			mok_q       <= 1'b0;
			held_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			sp2_q  <= {1'b0, sp_q} + 33'd2;
			sp14_q <= {1'b0, sp_q} + 33'd14;
			if (pop) begin
				if (head.last) begin
					sp_q   <= SP_RESET;
					walk_q <= 1'b0;
					fin_q  <= 1'b0;
					mok_q  <= 1'b0;
					held_q <= '0;
				end else begin
					sp_q   <= sp_n;
					walk_q <= walk_n;
					fin_q  <= fin_n;
					mok_q  <= mok_n;
					held_q <= held_n;
				end
			end
			if (pop && head.last) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign image_format = res_fmt_q;
	assign image_width  = res_wid_q;
	assign image_height = res_hgt_q;

endmodule

### rtl/image_header_size_parser_unit.sv
// Channel   Signals                                 Dir  Transfer when
// data      data_valid, data_stall, data_byte       in   data_valid & !data_stall
// result    result_valid, result_stall,             out  result_valid & !result_stall
//           image_format, image_width, image_height
// cfg       cfg_valid, cfg_ready, file_length       in   cfg_valid & cfg_ready
//
// One byte per clock sustained while result_stall holds back no last byte; the back end
// retires a byte each cycle it is not held. result_valid is registered: the file's last
// byte is taken into the byte queue, retired by the back end, and then result_valid rises.
// result_stall holds back only the last byte of the next file; other bytes flow.
// arst_n clears counters and the walk; byte stores need no reset and no sweep.
// data_stall rises only when the two-entry byte queue is full.

`include "assert_macros.svh"

module image_header_size_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  image_format,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] file_length
);
	import ihsp_pkg::*;

	// file length register, to be written only while idle; the block does not enforce this
	logic [31:0] flen_q;

	// front to queue
	logic  q_push;
	qent_t q_push_ent;
	logic  q_full;

	// queue to back
	logic  q_valid;
	logic  q_pop;
	qent_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= 32'(FILE_LEN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			flen_q <= file_length;
		end
	end

	// Front end: counts offsets and tags the file's final byte
	ihsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.file_length (flen_q),
		.q_full      (q_full),
		.push        (q_push),
		.push_ent    (q_push_ent)
	);

	// Decoupling queue
	ihsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_push_ent),
		.pop      (q_pop),
		.head     (q_head),
		.q_full   (q_full),
		.q_valid  (q_valid)
	);

	// Back end: header capture, segment walk, format decode, result register
	ihsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (q_head),
		.pop          (q_pop),
		.file_length  (flen_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.image_format (image_format),
		.image_width  (image_width),
		.image_height (image_height)
	);

	// a last byte never overwrites a result that is still waiting
	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, q_pop && q_head.last, !(result_valid && result_stall))
	// retiring a last byte always presents a result
	`ASSERT_NEXT(a_result_follows, clk, arst_n, q_pop && q_head.last, result_valid)
	// results come only from a retired last byte
	`ASSERT_IMPLIES(a_result_source, clk, arst_n, $rose(result_valid), $past(q_pop && q_head.last))

endmodule

### bench/tb_image_header_size_parser_unit.sv
`timescale 1ns / 100ps

module tb_image_header_size_parser_unit;

	import ihsp_pkg::*;

	// Marker and signature bytes used by the header decode and by the file builder
	localparam logic [7:0] MK_PREFIX    = 8'hFF;
	localparam logic [7:0] MK_SOI       = 8'hD8;
	localparam logic [7:0] MK_APP0      = 8'hE0;
	localparam logic [7:0] SOF_LO_FIRST = 8'hC0;
	localparam logic [7:0] SOF_LO_LAST  = 8'hC3;
	localparam logic [7:0] SOF_HI_FIRST = 8'hC9;
	localparam logic [7:0] SOF_HI_LAST  = 8'hCB;
	localparam logic [7:0] PNG_LEAD     = 8'h89;
	localparam logic [7:0] PNG_CR       = 8'h0D;
	localparam logic [7:0] PNG_LF       = 8'h0A;
	localparam logic [7:0] PNG_EOF      = 8'h1A;

	localparam int unsigned RING_DEPTH = 32;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef enum int {K_JFIF, K_JPEG, K_GIF, K_PNG, K_NOISE, K_BROKEN} file_kind_t;

	typedef struct packed {
		img_fmt_t    fmt;
		logic [31:0] w;
		logic [31:0] h;
	} img_dims_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  image_format;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] file_length = 32'd0;

	image_header_size_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.image_format(image_format),
		.image_width(image_width),
		.image_height(image_height),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.file_length(file_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bytes waiting for the driver, and sizes the block owes us, oldest first
	logic [7:0]  file_bytes_q[$];
	img_dims_t   expected_dims[$];
	logic [7:0]  img[];

	int unsigned mismatches = 0;
	int unsigned fed_bytes = 0;
	int unsigned hold_requests = 0;

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the length register and the stream
	// ------------------------------------------------------------------
	logic [31:0] length_reg;
	logic [31:0] offset_now;
	logic [7:0]  lead_bytes[HEADER_BYTES];
	logic [7:0]  byte_ring[RING_DEPTH];
	logic [31:0] window_at;
	logic        walking;
	logic        walk_done;
	logic        marker_good;
	logic [31:0] dim_shift;

	function automatic logic is_sof(input logic [7:0] m);
		return (m >= SOF_LO_FIRST && m <= SOF_LO_LAST) ||
			(m >= SOF_HI_FIRST && m <= SOF_HI_LAST);
	endfunction

	function automatic logic soi_app0(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		return b0 == MK_PREFIX && b1 == MK_SOI && b2 == MK_PREFIX && b3 == MK_APP0;
	endfunction

	// Fold one accepted byte into the stream state; on the file's last byte,
	// decode the header and queue the size the block must report.
	task automatic track_header_byte(input logic [7:0] b);
		logic [31:0]     i;
		longint unsigned wide_i, sp, np, seg;
		logic [7:0]      m0, m1;
		logic            jfif;
		img_dims_t       got;
		i = offset_now;
		wide_i = i;
		if (i < HEADER_BYTES)
			lead_bytes[i] = b;
		byte_ring[i % RING_DEPTH] = b;

		if (i == 32'd3)
			walking = soi_app0(lead_bytes[0], lead_bytes[1], lead_bytes[2], lead_bytes[3]);
		if (i == 32'd9 && walking && !(lead_bytes[6] == "J" && lead_bytes[7] == "F" &&
				lead_bytes[8] == "I" && lead_bytes[9] == "F"))
			walking = 1'b0;

		// Segment window decision on its fourth byte (the low length byte)
		sp = window_at;
		if (walking && wide_i == sp + 3) begin
			m0 = byte_ring[(i - 32'd3) % RING_DEPTH];
			m1 = byte_ring[(i - 32'd2) % RING_DEPTH];
			seg = {48'h0, byte_ring[(i - 32'd1) % RING_DEPTH], b};
			if (m0 != MK_PREFIX) begin
				walk_done = 1'b1;
				marker_good = 1'b0;
				walking = 1'b0;
			end else if (is_sof(m1)) begin
				walk_done = 1'b1;
				marker_good = 1'b1;
				walking = 1'b0;
			end else begin
				np = sp + 2 + seg;
				if (np + 12 > length_reg) begin
					walk_done = 1'b1;
					marker_good = 1'b1;
					walking = 1'b0;
				end else begin
					window_at = np[31:0];
				end
			end
		end

		// Window bytes 5..8 hold height and width
		sp = window_at;
		if (wide_i >= sp + 5 && wide_i <= sp + 8)
			dim_shift = {dim_shift[23:0], b};

		if (i == length_reg - 32'd1) begin
			got.fmt = FMT_NONE;
			got.w = 32'd0;
			got.h = 32'd0;
			if (length_reg >= HEADER_BYTES) begin
				jfif = soi_app0(lead_bytes[0], lead_bytes[1], lead_bytes[2], lead_bytes[3]) &&
					lead_bytes[6] == "J" && lead_bytes[7] == "F" &&
					lead_bytes[8] == "I" && lead_bytes[9] == "F";
				if (jfif) begin
					if (walk_done && marker_good) begin
						got.fmt = FMT_JPEG;
						got.h = {16'h0, dim_shift[31:16]};
						got.w = {16'h0, dim_shift[15:0]};
					end
				end else if (lead_bytes[0] == MK_PREFIX && lead_bytes[1] == MK_SOI &&
						lead_bytes[2] == MK_PREFIX) begin
					got.fmt = FMT_JPEG;
					got.h = {16'h0, lead_bytes[7], lead_bytes[8]};
					got.w = {16'h0, lead_bytes[9], lead_bytes[10]};
				end else if (lead_bytes[0] == "G" && lead_bytes[1] == "I" &&
						lead_bytes[2] == "F") begin
					got.fmt = FMT_GIF;
					got.w = {16'h0, lead_bytes[7], lead_bytes[6]};
					got.h = {16'h0, lead_bytes[9], lead_bytes[8]};
				end else if (lead_bytes[0] == PNG_LEAD && lead_bytes[1] == "P" &&
						lead_bytes[2] == "N" && lead_bytes[3] == "G" &&
						lead_bytes[4] == PNG_CR && lead_bytes[5] == PNG_LF &&
						lead_bytes[6] == PNG_EOF && lead_bytes[7] == PNG_LF &&
						lead_bytes[12] == "I" && lead_bytes[13] == "H" &&
						lead_bytes[14] == "D" && lead_bytes[15] == "R") begin
					got.fmt = FMT_PNG;
					got.w = {lead_bytes[16], lead_bytes[17], lead_bytes[18], lead_bytes[19]};
					got.h = {lead_bytes[20], lead_bytes[21], lead_bytes[22], lead_bytes[23]};
				end
			end
			expected_dims.insert(expected_dims.size(), got);
			// rearm for the next file; the byte stores keep their contents
			offset_now = 32'd0;
			window_at = 32'd2;
			walking = 1'b0;
			walk_done = 1'b0;
			marker_good = 1'b0;
			dim_shift = 32'd0;
		end else begin
			offset_now = i + 32'd1;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps, payload held while stalled.
	// Also the point where transfers are predicted.
	// ------------------------------------------------------------------
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			length_reg = FILE_LEN_RESET;
			offset_now = 32'd0;
			window_at = 32'd2;
			walking = 1'b0;
			walk_done = 1'b0;
			marker_good = 1'b0;
			dim_shift = 32'd0;
			foreach (lead_bytes[n])
				lead_bytes[n] = 8'h00;
			foreach (byte_ring[n])
				byte_ring[n] = 8'h00;
		end else begin
			if (cfg_valid && cfg_ready)
				length_reg = file_length;
			if (data_valid && !data_stall)
				track_header_byte(data_byte);
			if (!data_valid || !data_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					data_valid <= 1'b0;
				end else if (file_bytes_q.size() != 0) begin
					data_valid <= 1'b1;
					data_byte <= file_bytes_q.pop_front();
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						// a third of the bursts run straight into the next one
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side stall: changing patterns, plus long hold-offs on request
	// ------------------------------------------------------------------
	int unsigned hold_left;
	int unsigned holds_taken;
	int unsigned pattern_left;
	int unsigned pattern_mode;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
			holds_taken = 0;
			pattern_left = 0;
			pattern_mode = 0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (holds_taken != hold_requests) begin
			holds_taken++;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_mode = $urandom_range(0, 3);
				pattern_left = $urandom_range(8, 60);
			end else begin
				pattern_left--;
			end
			case (pattern_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= $urandom_range(0, 1);
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transfer against the oldest expected size
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		img_dims_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_dims.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: fmt %0d w %h h %h",
						image_format, image_width, image_height);
			end else begin
				want = expected_dims.pop_front();
				if (image_format !== want.fmt || image_width !== want.w ||
						image_height !== want.h) begin
					mismatches++;
					if (mismatches <= 10)
						$display("size mismatch: exp fmt %0d w %h h %h, got fmt %0d w %h h %h",
							want.fmt, want.w, want.h, image_format, image_width, image_height);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// File building
	// ------------------------------------------------------------------
	task automatic jfif_head(input logic [15:0] seg0);
		img[0] = MK_PREFIX;
		img[1] = MK_SOI;
		img[2] = MK_PREFIX;
		img[3] = MK_APP0;
		img[4] = seg0[15:8];
		img[5] = seg0[7:0];
		img[6] = "J";
		img[7] = "F";
		img[8] = "I";
		img[9] = "F";
	endtask

	task automatic put_window(input int unsigned p, input logic [7:0] pre,
			input logic [7:0] mk, input logic [15:0] seg);
		img[p] = pre;
		img[p + 1] = mk;
		img[p + 2] = seg[15:8];
		img[p + 3] = seg[7:0];
	endtask

	// Random content with plenty of 00 and FF, then the format's signature.
	// Short files get a 24-byte buffer so the signature lands anyway; only
	// the file's own length is shipped.
	task automatic make_file(input file_kind_t kind, input int unsigned len);
		int unsigned p, seg, k;
		logic [7:0]  mk, pre;
		file_kind_t  base;
		img = new[len < HEADER_BYTES ? HEADER_BYTES : len];
		foreach (img[n]) begin
			case ($urandom_range(0, 7))
				0: img[n] = 8'h00;
				1: img[n] = 8'hFF;
				default: img[n] = 8'($urandom_range(0, 255));
			endcase
		end
		base = (kind == K_BROKEN) ? file_kind_t'($urandom_range(0, 3)) : kind;
		case (base)
			K_JFIF: begin
				jfif_head(16'($urandom_range(6, 20)));
				p = 4 + {img[4], img[5]};
				// chain of segments until a frame marker, a missing FF prefix or the end is near
				while (p + 12 <= img.size()) begin
					k = $urandom_range(0, 6);
					mk = ($urandom_range(0, 5) == 0) ?
						((k < 4) ? 8'(SOF_LO_FIRST + k) : 8'(SOF_HI_FIRST + k - 4)) :
						8'($urandom_range(0, 255));
					seg = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535) :
						$urandom_range(2, 24);
					pre = ($urandom_range(0, 24) == 0) ? 8'h00 : MK_PREFIX;
					put_window(p, pre, mk, 16'(seg));
					if (pre != MK_PREFIX || is_sof(mk))
						break;
					p = p + 2 + seg;
				end
			end
			K_JPEG: begin
				img[0] = MK_PREFIX;
				img[1] = MK_SOI;
				img[2] = MK_PREFIX;
			end
			K_GIF: begin
				img[0] = "G";
				img[1] = "I";
				img[2] = "F";
			end
			K_PNG: begin
				img[0] = PNG_LEAD;
				img[1] = "P";
				img[2] = "N";
				img[3] = "G";
				img[4] = PNG_CR;
				img[5] = PNG_LF;
				img[6] = PNG_EOF;
				img[7] = PNG_LF;
				img[12] = "I";
				img[13] = "H";
				img[14] = "D";
				img[15] = "R";
			end
			default: ;
		endcase
		// broken file: one flipped bit somewhere in the signature area
		if (kind == K_BROKEN) begin
			k = $urandom_range(0, 15);
			img[k] = img[k] ^ 8'(1 << $urandom_range(0, 7));
		end
	endtask

	function automatic file_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return K_JFIF;
		else if (r < 10)
			return K_PNG;
		else if (r < 13)
			return K_GIF;
		else if (r < 15)
			return K_JPEG;
		else if (r < 17)
			return K_NOISE;
		return K_BROKEN;
	endfunction

	task automatic ship(input int unsigned len);
		for (int unsigned n = 0; n < len; n++)
			file_bytes_q.insert(file_bytes_q.size(), img[n]);
		fed_bytes += len;
	endtask

	// Length register write; only called with the block idle
	task automatic set_length(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		file_length <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every byte went in and every size came out, then let the
	// pipeline drain before anything touches the register.
	task automatic settle();
		do
			@(posedge clk);
		while (file_bytes_q.size() != 0 || data_valid || expected_dims.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned len;
		int unsigned nfiles;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// widest length setting; nothing is streamed under it
		set_length(32'hFFFF_FFFF);

		// one-byte file, then a short file that starts like a PNG
		set_length(32'd1);
		make_file(K_NOISE, 1);
		ship(1);
		settle();
		set_length(32'd23);
		make_file(K_PNG, 23);
		ship(23);
		settle();

		// minimum decodable length: every non-walk format and field extremes
		set_length(32'd24);
		make_file(K_PNG, 24);
		for (int n = 16; n < 20; n++)
			img[n] = 8'hFF;
		for (int n = 20; n < 24; n++)
			img[n] = 8'h00;
		ship(24);
		make_file(K_GIF, 24);
		img[6] = 8'hFF;
		img[7] = 8'hFF;
		img[8] = 8'h01;
		img[9] = 8'h00;
		ship(24);
		make_file(K_JPEG, 24);
		img[3] = 8'hE1;
		ship(24);
		// APP0 but no JFIF tag: falls back to the plain JPEG header read
		make_file(K_JPEG, 24);
		img[3] = MK_APP0;
		img[6] = 8'h00;
		ship(24);
		// PNG signature with a bad chunk name
		make_file(K_PNG, 24);
		img[13] = "X";
		ship(24);
		make_file(K_NOISE, 24);
		img[0] = 8'h00;
		ship(24);
		settle();

		// JFIF walks
		set_length(32'd40);
		// first segment already runs past the end
		make_file(K_NOISE, 40);
		jfif_head(16'h0100);
		ship(40);
		// second window lacks its FF
		make_file(K_NOISE, 40);
		jfif_head(16'd16);
		put_window(20, 8'h7F, SOF_LO_FIRST, 16'd0);
		ship(40);
		// no frame marker; walk ends because the next window won't fit
		make_file(K_NOISE, 40);
		jfif_head(16'd16);
		put_window(20, MK_PREFIX, 8'hDB, 16'd8);
		ship(40);
		// each frame marker in turn
		for (int unsigned k = 0; k < 7; k++) begin
			make_file(K_NOISE, 40);
			jfif_head(16'd16);
			put_window(20, MK_PREFIX,
				(k < 4) ? 8'(SOF_LO_FIRST + k) : 8'(SOF_HI_FIRST + k - 4), 16'd17);
			ship(40);
		end
		settle();

		// one long walk
		set_length(32'd400);
		make_file(K_JFIF, 400);
		ship(400);
		settle();

		// back pressure: results held off while short files keep coming
		set_length(32'd24);
		hold_requests++;
		repeat (8) begin
			make_file(pick_kind(), 24);
			ship(24);
		end
		settle();

		// random files, grouped by length so several run back to back
		while (fed_bytes < 1300) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 23);
				1: len = $urandom_range(100, 300);
				default: len = $urandom_range(24, 64);
			endcase
			nfiles = (len > 100) ? 1 : $urandom_range(1, 4);
			set_length(len);
			repeat (nfiles) begin
				make_file(pick_kind(), len);
				ship(len);
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_image_header_size_parser_unit: clean");
		else
			$display("tb_image_header_size_parser_unit: errors");
		$finish;
	end

	// hang guard, several times the slowest expected run
	initial begin
		#3000000;
		$display("tb_image_header_size_parser_unit: errors");
		$finish;
	end

endmodule

### image_header_size_parser_unit.f
+incdir+rtl
rtl/ihsp_pkg.sv
rtl/ihsp_front.sv
rtl/ihsp_queue.sv
rtl/ihsp_back.sv
rtl/image_header_size_parser_unit.sv
bench/tb_image_header_size_parser_unit.sv
